[rtl/core/h2r_pkg.sv]
// ============================================================================
// h2r_pkg
// Shared types, register indexes and hue helpers for the HSL to RGB converter.
// ============================================================================
package h2r_pkg;

    localparam int NUM_STAGES = 5;

    localparam logic [7:0] REG_HUE = 8'd0;
    localparam logic [7:0] REG_SAT = 8'd1;

    localparam logic [7:0] HUE_RST = 8'd20;
    localparam logic [7:0] SAT_RST = 8'd240;

    // hue position in 1/768 turn
    localparam logic [9:0] TURN      = 10'd768;
    localparam logic [9:0] THIRD     = 10'd256;
    localparam logic [9:0] RISE_END  = 10'd128;
    localparam logic [9:0] FLAT_END  = 10'd384;
    localparam logic [9:0] FALL_END  = 10'd512;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_chan;

    typedef struct packed {
        logic       use_q;
        logic [7:0] ramp;
    } t_hue_sel;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } t_pipe_ctl;

    // level = base*128 + (q - p)*ramp, base = q when use_q else p
    function automatic t_hue_sel hue_sel(input logic [7:0] hue, input t_chan ch);
        logic [9:0] h3;
        logic [9:0] sum;
        logic [9:0] pos;
        logic [9:0] fall;
        t_hue_sel   sel;
        h3   = {1'b0, hue, 1'b0} + {2'b00, hue};
        sum  = h3 + THIRD;
        case (ch)
            CH_RED:  pos = (sum > TURN) ? (sum - TURN) : sum;
            CH_BLUE: pos = (h3 < THIRD) ? (h3 + (TURN - THIRD)) : (h3 - THIRD);
            default: pos = h3;
        endcase
        fall      = FALL_END - pos;
        sel.use_q = 1'b0;
        sel.ramp  = 8'd0;
        if (pos < RISE_END) begin
            sel.ramp = pos[7:0];
        end else if (pos < FLAT_END) begin
            sel.use_q = 1'b1;
        end else if (pos < FALL_END) begin
            sel.ramp = fall[7:0];
        end
        return sel;
    endfunction

endpackage

[rtl/core/hsl_to_rgb_converter_top.sv]
// ============================================================================
// hsl_to_rgb_converter_top
// HSL to RGB converter: lightness per transfer, hue and saturation from regs.
// ============================================================================
// Channel   Dir  Handshake                    Payload
// s_axis    in   i_s_tvalid / o_s_tready      lightness [LIGHT_FRAC_BITS:0]
// m_axis    out  o_m_tvalid / i_m_tready      red [7:0], green [15:8], blue [23:16]
// cfg       in   i_cfg_valid / o_cfg_ready    index 0 hue, 1 saturation
//
// One transfer per clock in and out while the output is not stalled; five register stages:
// clamp and l*s multiply, q/p, ramp multiply, level sum, x255 scale.
// Reset clears stage valid bits and loads hue 20, saturation 240.
// Stalls back up stage by stage; empty stages keep accepting.
// Config is always ready; write only while the pipeline is empty.
// ============================================================================
module hsl_to_rgb_converter_top
    import h2r_pkg::*;
#(
    parameter int LIGHT_FRAC_BITS = 16,
    localparam int S_TW = ((LIGHT_FRAC_BITS + 8) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [S_TW-1:0] i_s_tdata,   // lightness
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [23:0]     o_m_tdata,   // red, green, blue
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [7:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data
);

    localparam int QW = LIGHT_FRAC_BITS + 9;

    logic [7:0]            r_hue;
    logic [7:0]            r_sat;
    logic [NUM_STAGES-1:0] r_vld;
    t_pipe_ctl             n_ctl;
    logic [QW-1:0]         qn;
    logic [QW-1:0]         pn;
    logic [QW-1:0]         diff;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue <= HUE_RST;
            r_sat <= SAT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HUE: r_hue <= i_cfg_data;
                REG_SAT: r_sat <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_ctl.load[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            n_ctl.load[k] = !r_vld[k] || n_ctl.load[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_ctl.load[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (n_ctl.load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = n_ctl.load[0];
    assign o_m_tvalid = r_vld[NUM_STAGES-1];

    h2r_qp #(
        .LIGHT_FRAC_BITS(LIGHT_FRAC_BITS)
    ) u_qp (
        .i_clk   (i_clk),
        .i_ctl   (n_ctl),
        .i_light (i_s_tdata[LIGHT_FRAC_BITS:0]),
        .i_sat   (r_sat),
        .o_qn    (qn),
        .o_pn    (pn),
        .o_diff  (diff)
    );

    h2r_chan #(
        .LIGHT_FRAC_BITS(LIGHT_FRAC_BITS)
    ) u_red (
        .i_clk   (i_clk),
        .i_ctl   (n_ctl),
        .i_sel   (hue_sel(r_hue, CH_RED)),
        .i_qn    (qn),
        .i_pn    (pn),
        .i_diff  (diff),
        .o_level (red)
    );

    h2r_chan #(
        .LIGHT_FRAC_BITS(LIGHT_FRAC_BITS)
    ) u_green (
        .i_clk   (i_clk),
        .i_ctl   (n_ctl),
        .i_sel   (hue_sel(r_hue, CH_GREEN)),
        .i_qn    (qn),
        .i_pn    (pn),
        .i_diff  (diff),
        .o_level (green)
    );

    h2r_chan #(
        .LIGHT_FRAC_BITS(LIGHT_FRAC_BITS)
    ) u_blue (
        .i_clk   (i_clk),
        .i_ctl   (n_ctl),
        .i_sel   (hue_sel(r_hue, CH_BLUE)),
        .i_qn    (qn),
        .i_pn    (pn),
        .i_diff  (diff),
        .o_level (blue)
    );

    assign o_m_tdata = {blue, green, red};

    // back-pressure only when every stage holds an item
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_vld))
        else $error("input blocked with a bubble in the pipeline");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted transfer not captured in first stage");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

[rtl/core/h2r_qp.sv]
// ============================================================================
// h2r_qp
// Lightness clamp and the HSL helper values q, p and q - p (two stages).
// ============================================================================
module h2r_qp
    import h2r_pkg::*;
#(
    parameter int LIGHT_FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  t_pipe_ctl                  i_ctl,
    input  logic [LIGHT_FRAC_BITS:0]   i_light,
    input  logic [7:0]                 i_sat,
    output logic [LIGHT_FRAC_BITS+8:0] o_qn,
    output logic [LIGHT_FRAC_BITS+8:0] o_pn,
    output logic [LIGHT_FRAC_BITS+8:0] o_diff
);

    localparam int LW = LIGHT_FRAC_BITS + 1;
    localparam int XW = LIGHT_FRAC_BITS + 8;
    localparam int QW = LIGHT_FRAC_BITS + 9;
    localparam logic [LW-1:0] ONE  = LW'(1) << LIGHT_FRAC_BITS;
    localparam logic [LW-1:0] HALF = ONE >> 1;

    logic [LW-1:0] n_l;
    logic [LW-1:0] r_l;
    logic [XW-1:0] r_ls;
    logic          r_lower;
    logic [XW-1:0] n_x;
    logic [QW-1:0] n_base;
    logic [QW-1:0] r_qn;
    logic [QW-1:0] r_pn;
    logic [QW-1:0] r_diff;

    assign n_l = (i_light > ONE) ? ONE : i_light;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_l     <= n_l;
            r_ls    <= XW'(n_l) * XW'(i_sat);
            r_lower <= (n_l < HALF);
        end
    end

    // q = l*256 + x, p = l*256 - x
    assign n_x    = r_lower ? r_ls : ({i_sat, {LIGHT_FRAC_BITS{1'b0}}} - r_ls);
    assign n_base = {r_l, 8'h00};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_qn   <= n_base + QW'(n_x);
            r_pn   <= n_base - QW'(n_x);
            r_diff <= {n_x, 1'b0};
        end
    end

    assign o_qn   = r_qn;
    assign o_pn   = r_pn;
    assign o_diff = r_diff;

endmodule

[rtl/core/h2r_chan.sv]
// ============================================================================
// h2r_chan
// One color channel: hue ramp product, level sum, and floor(255*level) scale.
// ============================================================================
module h2r_chan
    import h2r_pkg::*;
#(
    parameter int LIGHT_FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  t_pipe_ctl                  i_ctl,
    input  t_hue_sel                   i_sel,
    input  logic [LIGHT_FRAC_BITS+8:0] i_qn,
    input  logic [LIGHT_FRAC_BITS+8:0] i_pn,
    input  logic [LIGHT_FRAC_BITS+8:0] i_diff,
    output logic [7:0]                 o_level
);

    localparam int QW = LIGHT_FRAC_BITS + 9;
    localparam int NW = LIGHT_FRAC_BITS + 16;
    localparam int SW = LIGHT_FRAC_BITS + 24;

    t_hue_sel      r_sel;
    logic [NW-1:0] r_prod;
    logic [QW-1:0] r_base;
    logic [NW-1:0] r_num;
    logic [SW-1:0] n_scaled;
    logic [8:0]    n_top;
    logic [7:0]    r_level;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_sel <= i_sel;
        end
        if (i_ctl.load[2]) begin
            r_prod <= NW'(i_diff) * NW'(r_sel.ramp);
            r_base <= r_sel.use_q ? i_qn : i_pn;
        end
        if (i_ctl.load[3]) begin
            r_num <= {r_base, 7'd0} + r_prod;
        end
        if (i_ctl.load[4]) begin
            r_level <= n_top[8] ? 8'hff : n_top[7:0];
        end
    end

    // num*255 = num*256 - num
    assign n_scaled = {r_num, 8'h00} - {8'h00, r_num};
    assign n_top    = n_scaled[SW-1:LIGHT_FRAC_BITS+15];
    assign o_level  = r_level;

endmodule
